// ----- hdl/slq_pkg.sv -----
// Shared types, constants and word helpers for the subleq machine core.
// Depends on nothing; slq_ctrl, slq_out and the top level take their names from here by scope.
package slq_pkg;

    // Word memory depth in words; a power of two, so address wrap is a bit select.
    localparam int MEM_WORDS    = 1024;
    // Width of a machine word and of the program counter.
    localparam int WORD_BITS    = 16;
    localparam int ADDR_BITS    = $clog2(MEM_WORDS);
    // Fixed widths of the stream fields.
    localparam int FIELD_BITS   = 16;
    localparam int IN_ADDR_BITS = 10;
    localparam int CMD_BITS     = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_SET   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_OUT
    } t_state;

    // One finished result on its way to the output register.
    typedef struct packed {
        logic [FIELD_BITS-1:0] read_value;
        logic [FIELD_BITS-1:0] pc_value;
        logic                  halted;
        logic                  jumped;
    } t_result;

    // Sign-extend a 16-bit stream field and keep it to a machine word.
    function automatic t_word field_to_word(input logic signed [FIELD_BITS-1:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        return t[WORD_BITS-1:0];
    endfunction

    // Low 16 bits of a machine word, zero-filled when the word is narrower.
    function automatic logic [FIELD_BITS-1:0] word_to_field(input t_word w);
        logic [63:0] t;
        t = 64'(w);
        return t[FIELD_BITS-1:0];
    endfunction

    // Signed word reduced modulo the memory size: the low bits of its sign extension.
    function automatic t_addr word_to_addr(input t_word w);
        logic signed [63:0] t;
        t = 64'(signed'(w));
        return t[ADDR_BITS-1:0];
    endfunction

    // Stream address reduced modulo the memory size.
    function automatic t_addr field_to_addr(input logic [IN_ADDR_BITS-1:0] a);
        logic [63:0] t;
        t = 64'(a);
        return t[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- hdl/slq_ram.sv -----
// Generic single-port RAM with a registered read, one access per cycle.
// Depends on nothing.
module slq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/slq_ctrl.sv -----
// Command sequencer: memory clear pass, word access and the subleq step.
// Depends on slq_pkg; drives the single port of the word memory.
module slq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  slq_pkg::t_cmd                     i_command,
    input  logic [slq_pkg::IN_ADDR_BITS-1:0]  i_address,
    input  logic [slq_pkg::FIELD_BITS-1:0]    i_data_word,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output slq_pkg::t_result                  o_result,
    output logic                              o_ram_we,
    output logic                              o_ram_re,
    output slq_pkg::t_addr                    o_ram_addr,
    output slq_pkg::t_word                    o_ram_wdata,
    input  slq_pkg::t_word                    i_ram_rdata
);

    slq_pkg::t_state r_state, n_state;
    slq_pkg::t_word  r_pc, n_pc;
    slq_pkg::t_addr  r_a, n_a;
    slq_pkg::t_addr  r_b, n_b;
    slq_pkg::t_word  r_c, n_c;
    slq_pkg::t_word  r_va, n_va;
    slq_pkg::t_word  r_val, n_val;
    logic            r_jmp, n_jmp;
    slq_pkg::t_addr  r_clr, n_clr;

    slq_pkg::t_addr  pc_base;
    slq_pkg::t_word  diff;

    assign pc_base = slq_pkg::word_to_addr(r_pc);
    assign diff    = i_ram_rdata - r_va;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slq_pkg::ST_CLEAR;
            r_pc    <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_va  <= n_va;
        r_val <= n_val;
        r_jmp <= n_jmp;
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_va        = r_va;
        n_val       = r_val;
        n_jmp       = r_jmp;
        n_clr       = r_clr;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_addr  = pc_base;
        o_ram_wdata = '0;

        unique case (r_state)
            slq_pkg::ST_CLEAR: begin
                o_ram_we   = 1'b1;
                o_ram_addr = r_clr;
                n_clr      = r_clr + slq_pkg::ADDR_BITS'(1);
                if (r_clr == slq_pkg::ADDR_BITS'(slq_pkg::MEM_WORDS - 1)) begin
                    n_state = slq_pkg::ST_IDLE;
                end
            end
            slq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_val      = '0;
                n_jmp      = 1'b0;
                if (i_in_valid) begin
                    unique case (i_command)
                        slq_pkg::CMD_WRITE: begin
                            o_ram_we    = 1'b1;
                            o_ram_addr  = slq_pkg::field_to_addr(i_address);
                            o_ram_wdata = slq_pkg::field_to_word(i_data_word);
                            n_state     = slq_pkg::ST_OUT;
                        end
                        slq_pkg::CMD_READ: begin
                            o_ram_re   = 1'b1;
                            o_ram_addr = slq_pkg::field_to_addr(i_address);
                            n_state    = slq_pkg::ST_READ;
                        end
                        slq_pkg::CMD_SET: begin
                            n_pc    = slq_pkg::field_to_word(i_data_word);
                            n_state = slq_pkg::ST_OUT;
                        end
                        default: begin
                            // A step on a halted machine only reports the state.
                            if (r_pc[slq_pkg::WORD_BITS-1]) begin
                                n_state = slq_pkg::ST_OUT;
                            end else begin
                                o_ram_re = 1'b1;
                                n_state  = slq_pkg::ST_FETCH_A;
                            end
                        end
                    endcase
                end
            end
            slq_pkg::ST_READ: begin
                n_val   = i_ram_rdata;
                n_state = slq_pkg::ST_OUT;
            end
            slq_pkg::ST_FETCH_A: begin
                n_a        = slq_pkg::word_to_addr(i_ram_rdata);
                o_ram_re   = 1'b1;
                o_ram_addr = pc_base + slq_pkg::ADDR_BITS'(1);
                n_state    = slq_pkg::ST_FETCH_B;
            end
            slq_pkg::ST_FETCH_B: begin
                n_b        = slq_pkg::word_to_addr(i_ram_rdata);
                o_ram_re   = 1'b1;
                o_ram_addr = pc_base + slq_pkg::ADDR_BITS'(2);
                n_state    = slq_pkg::ST_FETCH_C;
            end
            slq_pkg::ST_FETCH_C: begin
                n_c        = i_ram_rdata;
                o_ram_re   = 1'b1;
                o_ram_addr = r_a;
                n_state    = slq_pkg::ST_LOAD_A;
            end
            slq_pkg::ST_LOAD_A: begin
                n_va       = i_ram_rdata;
                o_ram_re   = 1'b1;
                o_ram_addr = r_b;
                n_state    = slq_pkg::ST_LOAD_B;
            end
            slq_pkg::ST_LOAD_B: begin
                o_ram_we    = 1'b1;
                o_ram_addr  = r_b;
                o_ram_wdata = diff;
                n_val       = diff;
                if (diff != '0 && !diff[slq_pkg::WORD_BITS-1]) begin
                    n_pc  = r_pc + slq_pkg::WORD_BITS'(3);
                    n_jmp = 1'b0;
                end else begin
                    n_pc  = r_c;
                    n_jmp = 1'b1;
                end
                n_state = slq_pkg::ST_OUT;
            end
            slq_pkg::ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = slq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_result.read_value = slq_pkg::word_to_field(r_val);
    assign o_result.pc_value   = slq_pkg::word_to_field(r_pc);
    assign o_result.halted     = r_pc[slq_pkg::WORD_BITS-1];
    assign o_result.jumped     = r_jmp;

endmodule

// ----- hdl/slq_out.sv -----
// Output register that holds one result item until the stream sink takes it.
// Depends on slq_pkg for the result type.
module slq_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  slq_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output slq_pkg::t_result o_result
);

    logic             r_valid;
    slq_pkg::t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hdl/subleq_machine_core.sv -----
// Write, set pc and a halted step go from accept straight to the output state; a read
// passes the read state first. Throughput: one item at a time; a step holds the block
// while the single memory port serves three fetches, two operand reads and the write-back.
// Reset: synchronous, active low; it zeroes the program counter and starts a clearing
// pass over all 1024 words (one word a cycle) during which no item is accepted.
// Top level of the subleq machine core; depends on slq_pkg, slq_ram, slq_ctrl and slq_out.
module subleq_machine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [9:0] address, [25:10] data_word, rest zero
    input  logic [1:0]  i_s_tuser,  // [1:0] command
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // [15:0] read_value, [31:16] pc_value, [32] halted,
                                    // [33] jumped, rest zero
);

    // The whole machine state except the program counter lives in one
    // single-port word memory; the sequencer reads it at most one word per cycle.
    logic             ram_we;
    logic             ram_re;
    slq_pkg::t_addr   ram_addr;
    slq_pkg::t_word   ram_wdata;
    slq_pkg::t_word   ram_rdata;

    // Finished result handed from the sequencer to the output register.
    logic             res_valid;
    logic             res_ready;
    slq_pkg::t_result res_data;
    slq_pkg::t_result out_data;

    slq_ram #(
        .WIDTH (slq_pkg::WORD_BITS),
        .DEPTH (slq_pkg::MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // The sequencer takes one item in its idle state, runs it against the
    // memory and waits in its output state until the output register has room.
    slq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_command   (slq_pkg::t_cmd'(i_s_tuser)),
        .i_address   (i_s_tdata[9:0]),
        .i_data_word (i_s_tdata[25:10]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (res_data),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    // The output register lets the next item enter while a result waits.
    slq_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .o_ready  (res_ready),
        .i_result (res_data),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_data)
    );

    assign o_m_tdata = {6'b0, out_data.jumped, out_data.halted,
                        out_data.pc_value, out_data.read_value};

endmodule

// ----- hdl/slq_checker.sv -----
// Port-level checks for the subleq machine core, attached by a bind.
// Depends only on the top level's ports.
module slq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata
);

    // The halted flag always mirrors the sign of the reported program counter.
    a_halted_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[32] == i_m_tdata[31]))
        else $error("halted flag disagrees with pc sign");

    // A branch is taken only when the stored result is zero or negative.
    a_jump_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[33]) |-> (i_m_tdata[15:0] == 16'd0 || i_m_tdata[15]))
        else $error("branch reported for a positive result");

    // A stalled result item stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result item changed");

endmodule

bind subleq_machine_core slq_checker u_slq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
